// ----- rtl/dsi_pkg.sv -----
// ----------------------------------------------------------------------------
// dsi_pkg
// Shared types, constants and helpers for the daylight schedule interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package dsi_pkg;

   // Channel count default for the top level
   localparam int CHANNELS_DEFAULT = 5;

   // Field widths
   localparam int MINUTE_W  = 11;
   localparam int SECOND_W  = 6;
   localparam int RAMP_W    = 8;
   localparam int LEVELS_W  = 35;
   localparam int LEVEL_W   = 7;
   localparam int CHAN_W    = 3;
   localparam int TARGET_W  = 10;
   localparam int SEG_W     = 3;
   localparam int CSR_IDX_W = 3;
   localparam int BP_COUNT  = 6;

   // Back-end arithmetic widths
   localparam int DT_W   = 17;               // seconds into a segment, < 86400
   localparam int DEN_W  = 14;               // segment length * 6, <= 8634
   localparam int NUM_W  = LEVEL_W + DT_W;   // level delta * seconds
   localparam int QUO_W  = TARGET_W;         // quotient stays below 1000

   // Time and level limits
   localparam logic [MINUTE_W-1:0] MINUTES_PER_DAY = 11'd1440;
   localparam logic [MINUTE_W-1:0] LAST_MINUTE     = 11'd1439;
   localparam logic [SECOND_W-1:0] LAST_SECOND     = 6'd59;
   localparam logic [RAMP_W-1:0]   RAMP_MAX        = 8'd240;
   localparam logic [LEVEL_W-1:0]  LEVEL_MAX       = 7'd100;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SUNRISE_MINUTE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SUNSET_MINUTE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SUNRISE_RAMP   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SUNSET_RAMP    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_AUTO_OFF_EN    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TURNOFF_MINUTE = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DAY_LEVELS     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_NIGHT_LEVELS   = 3'd7;

   // Register reset values
   localparam logic [MINUTE_W-1:0] RST_SUNRISE_MINUTE = 11'd420;
   localparam logic [MINUTE_W-1:0] RST_SUNSET_MINUTE  = 11'd1080;
   localparam logic [RAMP_W-1:0]   RST_SUNRISE_RAMP   = 8'd60;
   localparam logic [RAMP_W-1:0]   RST_SUNSET_RAMP    = 8'd60;
   localparam logic                RST_AUTO_OFF_EN    = 1'b1;
   localparam logic [MINUTE_W-1:0] RST_TURNOFF_MINUTE = 11'd1320;
   localparam logic [LEVELS_W-1:0] RST_DAY_LEVELS     = 35'd27054912100;
   localparam logic [LEVELS_W-1:0] RST_NIGHT_LEVELS   = 35'd0;

   // Breakpoint indexes
   localparam logic [SEG_W-1:0] BP_SUNRISE_START = 3'd0;
   localparam logic [SEG_W-1:0] BP_SUNRISE_END   = 3'd1;
   localparam logic [SEG_W-1:0] BP_SUNSET_START  = 3'd2;
   localparam logic [SEG_W-1:0] BP_SUNSET_END    = 3'd3;
   localparam logic [SEG_W-1:0] BP_TURNOFF_NIGHT = 3'd4;
   localparam logic [SEG_W-1:0] BP_TURNOFF_ZERO  = 3'd5;

   // Request transaction
   typedef struct packed {
      logic [MINUTE_W-1:0] minute_of_day;
      logic [SECOND_W-1:0] second_of_minute;
      logic                auto_active;
   } req_type;

   // Response transaction
   typedef struct packed {
      logic [CHAN_W-1:0]   channel;
      logic [TARGET_W-1:0] target_level;
      logic                last_channel;
   } rsp_type;

   // Schedule derived from the registers
   typedef struct packed {
      logic [BP_COUNT-1:0][MINUTE_W-1:0] tm;
      logic                              auto_off_en;
      logic [LEVELS_W-1:0]               day_levels;
      logic [LEVELS_W-1:0]               night_levels;
   } sched_type;

   // Matched segment handed from front to back
   typedef struct packed {
      logic [SEG_W-1:0]    seg;
      logic [MINUTE_W-1:0] st;
      logic [MINUTE_W-1:0] et;
      logic [MINUTE_W-1:0] ct;
      logic [SECOND_W-1:0] sec;
   } seg_type;

   // Minute register out of range reads as midnight
   function automatic logic [MINUTE_W-1:0] clean_minute(input logic [MINUTE_W-1:0] m);
      return (m > LAST_MINUTE) ? '0 : m;
   endfunction

   // Ramp out of range reads as zero
   function automatic logic [RAMP_W-1:0] clean_ramp(input logic [RAMP_W-1:0] r);
      return (r > RAMP_MAX) ? '0 : r;
   endfunction

   // Circular distance a - b on the day circle, both below 1440
   function automatic logic [MINUTE_W-1:0] wrap_diff(input logic [MINUTE_W-1:0] a,
                                                     input logic [MINUTE_W-1:0] b);
      logic [MINUTE_W:0] sum;
      sum = (a >= b) ? ({1'b0, a} - {1'b0, b})
                     : ({1'b0, a} + {1'b0, MINUTES_PER_DAY} - {1'b0, b});
      return sum[MINUTE_W-1:0];
   endfunction

   // Saturated 7-bit level of one channel; channels past the register read 0
   function automatic logic [LEVEL_W-1:0] level_at(input logic [LEVELS_W-1:0] packed_lv,
                                                   input logic [CHAN_W-1:0]   ch);
      logic [LEVEL_W-1:0] f;
      case (ch)
         3'd0: f = packed_lv[6:0];
         3'd1: f = packed_lv[13:7];
         3'd2: f = packed_lv[20:14];
         3'd3: f = packed_lv[27:21];
         3'd4: f = packed_lv[34:28];
         default: f = '0;
      endcase
      return (f > LEVEL_MAX) ? LEVEL_MAX : f;
   endfunction

   // Level held at a breakpoint
   function automatic logic [LEVEL_W-1:0] bp_level(input logic [SEG_W-1:0]   bp,
                                                   input logic               turnoff,
                                                   input logic [LEVEL_W-1:0] night,
                                                   input logic [LEVEL_W-1:0] day);
      logic [LEVEL_W-1:0] lv;
      case (bp)
         BP_SUNRISE_START: lv = turnoff ? '0 : night;
         BP_SUNRISE_END:   lv = day;
         BP_SUNSET_START:  lv = day;
         BP_SUNSET_END:    lv = night;
         BP_TURNOFF_NIGHT: lv = night;
         BP_TURNOFF_ZERO:  lv = '0;
         default:          lv = '0;
      endcase
      return lv;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/dsi_csr.sv -----
// ----------------------------------------------------------------------------
// dsi_csr
// Configuration registers and the registered schedule built from them.
// ----------------------------------------------------------------------------
`default_nettype none

module dsi_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_valid,
   input  wire logic [dsi_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [dsi_pkg::LEVELS_W-1:0]      csr_wdata,
   output      dsi_pkg::sched_type                sched
);

   logic [dsi_pkg::MINUTE_W-1:0] sunrise_minute_ff;
   logic [dsi_pkg::MINUTE_W-1:0] sunset_minute_ff;
   logic [dsi_pkg::RAMP_W-1:0]   sunrise_ramp_ff;
   logic [dsi_pkg::RAMP_W-1:0]   sunset_ramp_ff;
   logic                         auto_off_en_ff;
   logic [dsi_pkg::MINUTE_W-1:0] turnoff_minute_ff;
   logic [dsi_pkg::LEVELS_W-1:0] day_levels_ff;
   logic [dsi_pkg::LEVELS_W-1:0] night_levels_ff;

   dsi_pkg::sched_type sched_ff;
   dsi_pkg::sched_type sched_in;

   logic [dsi_pkg::MINUTE_W-1:0] rise;
   logic [dsi_pkg::MINUTE_W-1:0] set;
   logic [dsi_pkg::MINUTE_W-1:0] off;
   logic [dsi_pkg::MINUTE_W:0]   rise_end;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         sunrise_minute_ff <= dsi_pkg::RST_SUNRISE_MINUTE;
         sunset_minute_ff  <= dsi_pkg::RST_SUNSET_MINUTE;
         sunrise_ramp_ff   <= dsi_pkg::RST_SUNRISE_RAMP;
         sunset_ramp_ff    <= dsi_pkg::RST_SUNSET_RAMP;
         auto_off_en_ff    <= dsi_pkg::RST_AUTO_OFF_EN;
         turnoff_minute_ff <= dsi_pkg::RST_TURNOFF_MINUTE;
         day_levels_ff     <= dsi_pkg::RST_DAY_LEVELS;
         night_levels_ff   <= dsi_pkg::RST_NIGHT_LEVELS;
      end else if (csr_valid) begin
         case (csr_index)
            dsi_pkg::CSR_SUNRISE_MINUTE: sunrise_minute_ff <= csr_wdata[dsi_pkg::MINUTE_W-1:0];
            dsi_pkg::CSR_SUNSET_MINUTE:  sunset_minute_ff  <= csr_wdata[dsi_pkg::MINUTE_W-1:0];
            dsi_pkg::CSR_SUNRISE_RAMP:   sunrise_ramp_ff   <= csr_wdata[dsi_pkg::RAMP_W-1:0];
            dsi_pkg::CSR_SUNSET_RAMP:    sunset_ramp_ff    <= csr_wdata[dsi_pkg::RAMP_W-1:0];
            dsi_pkg::CSR_AUTO_OFF_EN:    auto_off_en_ff    <= csr_wdata[0];
            dsi_pkg::CSR_TURNOFF_MINUTE: turnoff_minute_ff <= csr_wdata[dsi_pkg::MINUTE_W-1:0];
            dsi_pkg::CSR_DAY_LEVELS:     day_levels_ff     <= csr_wdata;
            dsi_pkg::CSR_NIGHT_LEVELS:   night_levels_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Breakpoint minutes, ramps folded onto the day circle
   always_comb begin
      rise     = dsi_pkg::clean_minute(sunrise_minute_ff);
      set      = dsi_pkg::clean_minute(sunset_minute_ff);
      off      = dsi_pkg::clean_minute(turnoff_minute_ff);
      rise_end = {1'b0, rise} + (dsi_pkg::MINUTE_W+1)'(dsi_pkg::clean_ramp(sunrise_ramp_ff));
      if (rise_end >= {1'b0, dsi_pkg::MINUTES_PER_DAY})
         rise_end = rise_end - {1'b0, dsi_pkg::MINUTES_PER_DAY};

      sched_in                = '0;
      sched_in.tm[dsi_pkg::BP_SUNRISE_START] = rise;
      sched_in.tm[dsi_pkg::BP_SUNRISE_END]   = rise_end[dsi_pkg::MINUTE_W-1:0];
      sched_in.tm[dsi_pkg::BP_SUNSET_START]  =
         dsi_pkg::wrap_diff(set, dsi_pkg::MINUTE_W'(dsi_pkg::clean_ramp(sunset_ramp_ff)));
      sched_in.tm[dsi_pkg::BP_SUNSET_END]    = set;
      sched_in.tm[dsi_pkg::BP_TURNOFF_NIGHT] = off;
      sched_in.tm[dsi_pkg::BP_TURNOFF_ZERO]  = off;
      sched_in.auto_off_en    = auto_off_en_ff;
      sched_in.day_levels     = day_levels_ff;
      sched_in.night_levels   = night_levels_ff;
   end

   // Schedule register, a registered copy of the schedule built from the registers
   always_ff @(posedge clock) begin
      sched_ff <= sched_in;
   end

   assign sched = sched_ff;

endmodule

`default_nettype wire

// ----- rtl/dsi_front.sv -----
// ----------------------------------------------------------------------------
// dsi_front
// Accepts time transactions, drops invalid ones and finds the schedule segment.
// ----------------------------------------------------------------------------
`default_nettype none

module dsi_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output      logic                busy,
   input  wire dsi_pkg::req_type    req_payload,
   input  wire dsi_pkg::sched_type  sched,
   input  wire logic                queue_full,
   output      logic                push_valid,
   output      dsi_pkg::seg_type    push_data
);

   logic             in_valid_ff;
   logic             in_valid_in;
   dsi_pkg::req_type in_ff;

   logic                          accept;
   logic                          item_ok;
   logic [dsi_pkg::BP_COUNT-1:0]  hit;
   logic [dsi_pkg::MINUTE_W-1:0]  st_a [dsi_pkg::BP_COUNT];
   logic [dsi_pkg::MINUTE_W-1:0]  et_a [dsi_pkg::BP_COUNT];
   logic [dsi_pkg::MINUTE_W-1:0]  ct;

   // Input stage: stalls only while it holds a transaction and the queue is full
   assign busy    = in_valid_ff & queue_full;
   assign accept  = start & ~busy;
   assign item_ok = (req_payload.minute_of_day <= dsi_pkg::LAST_MINUTE) &&
                    (req_payload.second_of_minute <= dsi_pkg::LAST_SECOND) &&
                    req_payload.auto_active;
   assign in_valid_in = accept ? item_ok : (in_valid_ff & queue_full);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_ff <= req_payload;
      end
   end

   // Segment check for every breakpoint pair; the turn-off pairs only with auto-off on
   assign ct = in_ff.minute_of_day;

   always_comb begin
      for (int i = 0; i < dsi_pkg::BP_COUNT; i++) begin
         st_a[i] = sched.tm[i];
         if (sched.auto_off_en)
            et_a[i] = sched.tm[(i + 1) % dsi_pkg::BP_COUNT];
         else
            et_a[i] = sched.tm[(i + 1) % 4];
         if (!sched.auto_off_en && i >= 4)
            hit[i] = 1'b0;
         else if (et_a[i] >= st_a[i])
            hit[i] = (ct >= st_a[i]) && (ct < et_a[i]);
         else
            hit[i] = (ct >= st_a[i]) || (ct < et_a[i]);
      end
   end

   // Last matching segment wins
   always_comb begin
      push_data     = '0;
      push_data.ct  = ct;
      push_data.sec = in_ff.second_of_minute;
      for (int i = 0; i < dsi_pkg::BP_COUNT; i++) begin
         if (hit[i]) begin
            push_data.seg = dsi_pkg::SEG_W'(i);
            push_data.st  = st_a[i];
            push_data.et  = et_a[i];
         end
      end
   end

   assign push_valid = in_valid_ff & ~queue_full & (|hit);

endmodule

`default_nettype wire

// ----- rtl/dsi_queue.sv -----
// ----------------------------------------------------------------------------
// dsi_queue
// Two-entry queue of matched segments between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module dsi_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire dsi_pkg::seg_type push_data,
   input  wire logic             pop,
   output      logic             full,
   output      logic             head_valid,
   output      dsi_pkg::seg_type head_data
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);

   dsi_pkg::seg_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [PTR_W:0]   count_ff;
   logic [PTR_W:0]   count_in;

   assign full       = (count_ff == (PTR_W+1)'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop)
         count_in = count_ff + 1'b1;
      else if (!push && pop)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/dsi_back.sv -----
// ----------------------------------------------------------------------------
// dsi_back
// Channel sequencer, level pick, product and pipelined divider per channel.
// ----------------------------------------------------------------------------
`default_nettype none

module dsi_back #(
   parameter int CHANNELS = dsi_pkg::CHANNELS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire dsi_pkg::sched_type sched,
   input  wire logic               head_valid,
   input  wire dsi_pkg::seg_type   head_data,
   output      logic               pop,
   output      logic               rsp_valid,
   output      dsi_pkg::rsp_type   rsp_payload
);

   localparam logic [dsi_pkg::CHAN_W-1:0] CHAN_LAST = dsi_pkg::CHAN_W'(CHANNELS - 1);
   localparam int STAGES = dsi_pkg::QUO_W;

   typedef struct packed {
      logic [dsi_pkg::SEG_W-1:0] seg;
      logic [dsi_pkg::DT_W-1:0]  dt;
      logic [dsi_pkg::DEN_W-1:0] den;
   } job_type;

   typedef struct packed {
      logic [dsi_pkg::NUM_W-1:0]    rem;
      logic [dsi_pkg::DEN_W-1:0]    den;
      logic [dsi_pkg::QUO_W-1:0]    quo;
      logic [dsi_pkg::TARGET_W-1:0] base;
      logic                         neg;
      logic [dsi_pkg::CHAN_W-1:0]   channel;
      logic                         last;
   } div_type;

   // Job stage
   logic                       job_valid_ff;
   logic                       job_valid_in;
   job_type                    job_ff;
   job_type                    job_in;
   logic [dsi_pkg::CHAN_W-1:0] chan_ff;
   logic [dsi_pkg::CHAN_W-1:0] chan_in;
   logic                       chan_done;
   logic [dsi_pkg::MINUTE_W-1:0] since;
   logic [dsi_pkg::MINUTE_W-1:0] dur;

   // Level stage
   logic [dsi_pkg::LEVEL_W-1:0] night;
   logic [dsi_pkg::LEVEL_W-1:0] day;
   logic [dsi_pkg::LEVEL_W-1:0] lv_a;
   logic [dsi_pkg::LEVEL_W-1:0] lv_b;
   logic [dsi_pkg::LEVEL_W-1:0] delta;
   logic [dsi_pkg::SEG_W-1:0]   seg_next;
   div_type                     div_in;

   // Divider pipeline
   logic    div_valid_ff [STAGES+1];
   div_type div_ff       [STAGES+1];

   // Output stage
   logic             rsp_valid_ff;
   dsi_pkg::rsp_type rsp_ff;
   dsi_pkg::rsp_type rsp_in;

   // Channel sequencer: next segment enters as the last channel issues
   assign chan_done    = (chan_ff == CHAN_LAST);
   assign pop          = head_valid & (~job_valid_ff | chan_done);
   assign job_valid_in = pop | (job_valid_ff & ~chan_done);

   always_comb begin
      if (pop)
         chan_in = '0;
      else if (job_valid_ff)
         chan_in = chan_ff + 1'b1;
      else
         chan_in = chan_ff;
   end

   // Seconds into the segment and its length times six
   always_comb begin
      since      = dsi_pkg::wrap_diff(head_data.ct, head_data.st);
      dur        = dsi_pkg::wrap_diff(head_data.et, head_data.st);
      job_in.seg = head_data.seg;
      job_in.dt  = (dsi_pkg::DT_W'(since) << 6) - (dsi_pkg::DT_W'(since) << 2)
                   + dsi_pkg::DT_W'(head_data.sec);
      job_in.den = (dsi_pkg::DEN_W'(dur) << 2) + (dsi_pkg::DEN_W'(dur) << 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         chan_ff      <= '0;
      end else begin
         job_valid_ff <= job_valid_in;
         chan_ff      <= chan_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff <= job_in;
      end
   end

   // Start and end levels of the segment for this channel, then the product
   always_comb begin
      night    = dsi_pkg::level_at(sched.night_levels, chan_ff);
      day      = dsi_pkg::level_at(sched.day_levels, chan_ff);
      if (sched.auto_off_en)
         seg_next = (job_ff.seg == dsi_pkg::BP_TURNOFF_ZERO) ? dsi_pkg::BP_SUNRISE_START
                                                              : job_ff.seg + 1'b1;
      else
         seg_next = (job_ff.seg == dsi_pkg::BP_SUNSET_END) ? dsi_pkg::BP_SUNRISE_START
                                                            : job_ff.seg + 1'b1;
      lv_a     = dsi_pkg::bp_level(job_ff.seg, sched.auto_off_en, night, day);
      lv_b     = dsi_pkg::bp_level(seg_next, sched.auto_off_en, night, day);
      div_in.neg = (lv_b < lv_a);
      delta    = div_in.neg ? (lv_a - lv_b) : (lv_b - lv_a);
      div_in.rem = dsi_pkg::NUM_W'(delta) * dsi_pkg::NUM_W'(job_ff.dt);
      div_in.den = job_ff.den;
      div_in.quo = '0;
      div_in.base = (dsi_pkg::TARGET_W'(lv_a) << 3) + (dsi_pkg::TARGET_W'(lv_a) << 1);
      div_in.channel = chan_ff;
      div_in.last    = chan_done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_valid_ff[0] <= 1'b0;
      end else begin
         div_valid_ff[0] <= job_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      div_ff[0] <= div_in;
   end

   // Restoring divider, one quotient bit per stage, most significant first
   for (genvar j = 0; j < STAGES; j++) begin : g_div
      localparam int BIT = STAGES - 1 - j;
      logic [dsi_pkg::NUM_W-1:0] sub_den;
      div_type                   stage_in;

      always_comb begin
         sub_den  = dsi_pkg::NUM_W'(div_ff[j].den) << BIT;
         stage_in = div_ff[j];
         if (div_ff[j].rem >= sub_den) begin
            stage_in.rem      = div_ff[j].rem - sub_den;
            stage_in.quo[BIT] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_valid_ff[j+1] <= 1'b0;
         end else begin
            div_valid_ff[j+1] <= div_valid_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         div_ff[j+1] <= stage_in;
      end
   end

   // Final target and result register
   always_comb begin
      rsp_in.channel      = div_ff[STAGES].channel;
      rsp_in.last_channel = div_ff[STAGES].last;
      rsp_in.target_level = div_ff[STAGES].neg ? (div_ff[STAGES].base - div_ff[STAGES].quo)
                                               : (div_ff[STAGES].base + div_ff[STAGES].quo);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= div_valid_ff[STAGES];
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// ----- rtl/daylight_schedule_interpolator_core.sv -----
// ----------------------------------------------------------------------------
// daylight_schedule_interpolator_core
// Turns a time of day into per-channel target levels along a daily schedule.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: a transaction (minute, second, auto flag) is taken on a
//   clock edge with start high and busy low. Invalid times, an inactive flag
//   or a time outside every schedule segment produce no response.
//   Response channel: one transaction per channel, channel 0 first, on
//   consecutive cycles, each marked by rsp_valid for exactly one cycle;
//   last_channel flags the final one. The receiver cannot stall the block.
//   Configuration channel: csr_ready is always high; writes land at once. The
//   user must see that writes are issued only while no request is in flight;
//   the block itself does not enforce this.
// Pipeline: a request passes input, queue, job, divider and result registers.
//   The channel sequencer issues one divide per cycle, one per channel
//   (CHANNELS, 5 by default); a two-entry segment queue lets the front keep
//   taking requests while the back end works, and busy rises only when the
//   input stage holds a request and the queue is full.
// Reset: synchronous, clears all control state and reloads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module daylight_schedule_interpolator_core #(
   parameter int CHANNELS = dsi_pkg::CHANNELS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // Request channel
   input  wire logic                          start,
   output      logic                          busy,
   input  wire dsi_pkg::req_type              req_payload,
   // Response channel
   output      logic                          rsp_valid,
   output      dsi_pkg::rsp_type              rsp_payload,
   // Configuration channel
   input  wire logic                          csr_valid,
   output      logic                          csr_ready,
   input  wire logic [dsi_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [dsi_pkg::LEVELS_W-1:0]  csr_wdata
);

   dsi_pkg::sched_type sched;
   dsi_pkg::seg_type   push_data;
   dsi_pkg::seg_type   head_data;
   logic               push_valid;
   logic               queue_full;
   logic               head_valid;
   logic               pop;

   assign csr_ready = 1'b1;

   // Registers and schedule
   dsi_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .sched     (sched)
   );

   // Front: accept and segment match
   dsi_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .sched       (sched),
      .queue_full  (queue_full),
      .push_valid  (push_valid),
      .push_data   (push_data)
   );

   // Segment queue
   dsi_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_data  (push_data),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   // Back: per-channel interpolation
   dsi_back #(
      .CHANNELS (CHANNELS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .sched       (sched),
      .head_valid  (head_valid),
      .head_data   (head_data),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// ----- rtl/dsi_checker.sv -----
// ----------------------------------------------------------------------------
// dsi_checker
// Port-level checks on the response stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dsi_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_valid,
   input wire dsi_pkg::rsp_type rsp_payload
);

   // Nothing comes out right after reset
   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response strobe right after reset");

   // Channels of one request arrive back to back
   a_run_unbroken: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.last_channel |=> rsp_valid)
      else $error("gap inside a channel run");

   // Channel index steps by one inside a run
   a_channel_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.last_channel |=>
         rsp_payload.channel == 3'($past(rsp_payload.channel) + 3'd1))
      else $error("channel index did not advance by one");

   // Target stays within 0..1000 tenths
   a_target_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.target_level <= 10'd1000)
      else $error("target level out of range");

endmodule

bind daylight_schedule_interpolator_core dsi_checker u_dsi_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_payload (rsp_payload)
);

`default_nettype wire

// ----- tb/sv/tb_daylight_schedule_interpolator_core.sv -----
// ----------------------------------------------------------------------------
// tb_daylight_schedule_interpolator_core
// Self-checking bench for the daylight schedule interpolator. Times of day are
// pushed through the core under fixed and randomized schedules. Every
// per-channel target is checked against a behavioral model of the breakpoint
// search and the linear interpolation.
// ----------------------------------------------------------------------------

module tb_daylight_schedule_interpolator_core;

   import dsi_pkg::*;

   localparam int N_CHANNELS   = CHANNELS_DEFAULT;
   localparam int DRAIN_CYCLES = 48;       // covers the pipeline plus two queued requests
   localparam int LIMIT_CYCLES = 200000;
   localparam int IDLE_PCT     = 34;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 start;
   logic                 busy;
   req_type              req_payload;
   logic                 rsp_valid;
   rsp_type              rsp_payload;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [LEVELS_W-1:0]  csr_wdata;

   // Shadow copy of the schedule registers
   logic [MINUTE_W-1:0]  sched_sunrise;
   logic [MINUTE_W-1:0]  sched_sunset;
   logic [RAMP_W-1:0]    sched_rise_ramp;
   logic [RAMP_W-1:0]    sched_set_ramp;
   logic                 sched_off_enable;
   logic [MINUTE_W-1:0]  sched_off_minute;
   logic [LEVELS_W-1:0]  sched_day;
   logic [LEVELS_W-1:0]  sched_night;

   rsp_type              pending_targets[$];
   int                   mismatch_count = 0;
   int                   watchdog_cycles;
   bit                   idle_on = 1'b1;

   daylight_schedule_interpolator_core #(
      .CHANNELS(N_CHANNELS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_payload(rsp_payload),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Schedule model
   // ------------------------------------------------------------------------

   // out-of-range minute registers act as midnight
   function automatic int unsigned day_minute(input logic [MINUTE_W-1:0] m);
      return (m > LAST_MINUTE) ? 0 : m;
   endfunction

   // ramps longer than the maximum act as zero
   function automatic int unsigned ramp_len(input logic [RAMP_W-1:0] r);
      return (r > RAMP_MAX) ? 0 : r;
   endfunction

   // saturated percent of one channel; fields past the register read zero
   function automatic int unsigned pct_of(input logic [LEVELS_W-1:0] levels,
                                          input int unsigned ch);
      int unsigned v;
      if (ch * LEVEL_W >= LEVELS_W) return 0;
      v = 32'(levels >> (ch * LEVEL_W)) & 32'h7f;
      return (v > LEVEL_MAX) ? LEVEL_MAX : v;
   endfunction

   // queue the per-channel targets that one accepted time should produce
   function automatic void predict_targets(input req_type item);
      int unsigned bp [6];
      int unsigned lvl [6];
      int unsigned now_min, now_sec, n_bp, st, et, seg, span, elapsed;
      int unsigned start_pct, end_pct, night_pct, day_pct, tgt;
      bit          hit;
      rsp_type     rsp;
      now_min = item.minute_of_day;
      now_sec = item.second_of_minute;
      if (now_min > LAST_MINUTE || now_sec > LAST_SECOND || !item.auto_active) return;

      bp[0] = day_minute(sched_sunrise);
      bp[1] = (bp[0] + ramp_len(sched_rise_ramp)) % MINUTES_PER_DAY;
      bp[2] = (MINUTES_PER_DAY + day_minute(sched_sunset) - ramp_len(sched_set_ramp))
              % MINUTES_PER_DAY;
      bp[3] = day_minute(sched_sunset);
      bp[4] = day_minute(sched_off_minute);
      bp[5] = bp[4];
      n_bp  = sched_off_enable ? 6 : 4;

      // scan every segment; a later match overrides an earlier one
      hit = 1'b0;
      seg = 0;
      span = 1;
      elapsed = 0;
      for (int i = 0; i < n_bp; i++) begin
         st = bp[i];
         et = bp[(i + 1) % n_bp];
         if (et >= st) begin
            if (now_min >= st && now_min < et) begin
               hit = 1'b1;
               seg = i;
               span = et - st;
               elapsed = (now_min - st) * 60 + now_sec;
            end
         end else if (now_min >= st || now_min < et) begin
            // segment wraps through midnight
            hit = 1'b1;
            seg = i;
            span = MINUTES_PER_DAY - st + et;
            elapsed = ((now_min >= st) ? now_min - st : MINUTES_PER_DAY - st + now_min) * 60
                      + now_sec;
         end
      end
      if (!hit) return;

      for (int k = 0; k < N_CHANNELS; k++) begin
         night_pct = pct_of(sched_night, k);
         day_pct   = pct_of(sched_day, k);
         lvl[0] = sched_off_enable ? 0 : night_pct;
         lvl[1] = day_pct;
         lvl[2] = day_pct;
         lvl[3] = night_pct;
         lvl[4] = night_pct;
         lvl[5] = 0;
         start_pct = lvl[seg];
         end_pct   = lvl[(seg + 1) % n_bp];
         if (end_pct >= start_pct)
            tgt = start_pct * 10 + ((end_pct - start_pct) * elapsed) / (span * 6);
         else
            tgt = start_pct * 10 - ((start_pct - end_pct) * elapsed) / (span * 6);
         rsp.channel      = CHAN_W'(k);
         rsp.target_level = TARGET_W'(tgt);
         rsp.last_channel = (k == N_CHANNELS - 1);
         pending_targets.push_back(rsp);
      end
   endfunction

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("mismatch at %0t: %s", $time, what);
   endtask

   // every strobed result is matched against the oldest expected target
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_targets.size() == 0) begin
            report_mismatch($sformatf("unexpected result ch %0d level %0d last %0b",
                            rsp_payload.channel, rsp_payload.target_level,
                            rsp_payload.last_channel));
         end else begin
            want = pending_targets.pop_front();
            if (rsp_payload.channel !== want.channel)
               report_mismatch($sformatf("channel got %0d want %0d",
                               rsp_payload.channel, want.channel));
            if (rsp_payload.target_level !== want.target_level)
               report_mismatch($sformatf("ch %0d target_level got %0d want %0d",
                               want.channel, rsp_payload.target_level, want.target_level));
            if (rsp_payload.last_channel !== want.last_channel)
               report_mismatch($sformatf("ch %0d last_channel got %0b want %0b",
                               want.channel, rsp_payload.last_channel, want.last_channel));
         end
      end
   end

   // ------------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------------

   // one request transaction, with random idle cycles in front
   task automatic send_time(input int unsigned minute, input int unsigned sec,
                            input bit active);
      req_type item;
      item.minute_of_day    = MINUTE_W'(minute);
      item.second_of_minute = SECOND_W'(sec);
      item.auto_active      = active;
      while (idle_on && $urandom_range(99) < IDLE_PCT) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start       <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (busy);
      predict_targets(item);
   endtask

   // stop requests, let every expected target arrive, then let the pipe drain
   task automatic wait_idle();
      start <= 1'b0;
      while (pending_targets.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // one register write transaction; shadow copy updated on acceptance
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [LEVELS_W-1:0] value);
      while (idle_on && $urandom_range(99) < IDLE_PCT) begin
         csr_valid <= 1'b0;
         @(posedge clock);
      end
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_SUNRISE_MINUTE: sched_sunrise    = value[MINUTE_W-1:0];
         CSR_SUNSET_MINUTE:  sched_sunset     = value[MINUTE_W-1:0];
         CSR_SUNRISE_RAMP:   sched_rise_ramp  = value[RAMP_W-1:0];
         CSR_SUNSET_RAMP:    sched_set_ramp   = value[RAMP_W-1:0];
         CSR_AUTO_OFF_EN:    sched_off_enable = value[0];
         CSR_TURNOFF_MINUTE: sched_off_minute = value[MINUTE_W-1:0];
         CSR_DAY_LEVELS:     sched_day        = value;
         CSR_NIGHT_LEVELS:   sched_night      = value;
         default: ;
      endcase
   endtask

   // reprogram the whole schedule while the core is idle
   task automatic load_schedule(input int unsigned rise, input int unsigned set,
                                input int unsigned rise_ramp, input int unsigned set_ramp,
                                input bit off_en, input int unsigned off_min,
                                input logic [LEVELS_W-1:0] day,
                                input logic [LEVELS_W-1:0] night);
      wait_idle();
      write_register(CSR_SUNRISE_MINUTE, LEVELS_W'(rise));
      write_register(CSR_SUNSET_MINUTE,  LEVELS_W'(set));
      write_register(CSR_SUNRISE_RAMP,   LEVELS_W'(rise_ramp));
      write_register(CSR_SUNSET_RAMP,    LEVELS_W'(set_ramp));
      write_register(CSR_AUTO_OFF_EN,    LEVELS_W'(off_en));
      write_register(CSR_TURNOFF_MINUTE, LEVELS_W'(off_min));
      write_register(CSR_DAY_LEVELS,     day);
      write_register(CSR_NIGHT_LEVELS,   night);
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Random sources
   // ------------------------------------------------------------------------

   function automatic int unsigned rand_minute();
      case ($urandom_range(9))
         0:       return 0;
         1:       return LAST_MINUTE;
         2:       return $urandom_range(2047);   // may land above the last minute
         default: return $urandom_range(LAST_MINUTE);
      endcase
   endfunction

   function automatic int unsigned rand_ramp();
      case ($urandom_range(9))
         0:       return 0;
         1:       return RAMP_MAX;
         2:       return $urandom_range(255);
         default: return $urandom_range(RAMP_MAX);
      endcase
   endfunction

   function automatic logic [LEVELS_W-1:0] rand_levels();
      logic [LEVELS_W-1:0] v;
      case ($urandom_range(5))
         0: v = '0;
         1: v = '1;
         2, 3: begin
            for (int c = 0; c < LEVELS_W / LEVEL_W; c++)
               v[c * LEVEL_W +: LEVEL_W] = LEVEL_W'($urandom_range(LEVEL_MAX));
         end
         default: v = LEVELS_W'({$urandom, $urandom});
      endcase
      return v;
   endfunction

   // mostly legal active times, often next to a breakpoint; the rest is noise
   task automatic send_random_time();
      int unsigned anchor;
      if ($urandom_range(99) < 80) begin
         if ($urandom_range(2) == 0) begin
            case ($urandom_range(3))
               0: anchor = day_minute(sched_sunrise);
               1: anchor = (day_minute(sched_sunrise) + ramp_len(sched_rise_ramp))
                           % MINUTES_PER_DAY;
               2: anchor = day_minute(sched_sunset);
               default: anchor = day_minute(sched_off_minute);
            endcase
            anchor = (anchor + MINUTES_PER_DAY + $urandom_range(4) - 2) % MINUTES_PER_DAY;
            send_time(anchor, $urandom_range(LAST_SECOND), 1'b1);
         end else begin
            send_time($urandom_range(LAST_MINUTE), $urandom_range(LAST_SECOND), 1'b1);
         end
      end else begin
         send_time($urandom_range(2047), $urandom_range(63), $urandom_range(1));
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // default schedule: every segment, its edges, and the rejected inputs
   task automatic test_reset_schedule();
      send_time(0, 0, 1'b1);
      send_time(419, 59, 1'b1);
      send_time(420, 0, 1'b1);
      send_time(450, 30, 1'b1);
      send_time(480, 0, 1'b1);
      send_time(1050, 15, 1'b1);
      send_time(1080, 0, 1'b1);
      send_time(1319, 59, 1'b1);
      send_time(1320, 0, 1'b1);
      send_time(LAST_MINUTE, LAST_SECOND, 1'b1);
      send_time(MINUTES_PER_DAY, 0, 1'b1);      // minute out of range
      send_time(2047, 63, 1'b1);
      send_time(700, 60, 1'b1);                  // second out of range
      send_time(700, 0, 1'b0);                   // schedule inactive
   endtask

   // out-of-range registers, saturated levels, overlapping wrapped segments
   task automatic test_register_limits();
      load_schedule(2047, LAST_MINUTE, 255, RAMP_MAX, 1'b0, 2047, '1,
                    {7'd101, 7'd100, 7'd0, 7'd127, 7'd50});
      send_time(0, 0, 1'b1);
      send_time(600, 30, 1'b1);
      send_time(1300, 59, 1'b1);
      send_time(LAST_MINUTE, 30, 1'b1);
      load_schedule(LAST_MINUTE, 0, RAMP_MAX, 0, 1'b1, 0,
                    {7'd127, 7'd1, 7'd99, 7'd100, 7'd33}, '1);
      send_time(LAST_MINUTE, 0, 1'b1);
      send_time(100, 0, 1'b1);
      send_time(500, 0, 1'b1);
   endtask

   // all breakpoints on one minute: no segment holds any time
   task automatic test_empty_schedule();
      load_schedule(600, 600, 0, 0, 1'b0, 600, RST_DAY_LEVELS, '1);
      send_time(600, 0, 1'b1);
      send_time(0, 0, 1'b1);
      send_time(LAST_MINUTE, LAST_SECOND, 1'b1);
      load_schedule(600, 600, 0, 0, 1'b1, 600, RST_DAY_LEVELS, '1);
      send_time(601, 10, 1'b1);
   endtask

   // random schedules, one phase without any idling
   task automatic test_random_schedules();
      for (int phase = 0; phase < 9; phase++) begin
         idle_on = (phase != 3);
         load_schedule(rand_minute(), rand_minute(), rand_ramp(), rand_ramp(),
                       $urandom_range(1), rand_minute(), rand_levels(), rand_levels());
         repeat (40) send_random_time();
      end
      idle_on = 1'b1;
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------

   initial begin
      reset            = 1'b1;
      start            = 1'b0;
      req_payload      = '0;
      csr_valid        = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      sched_sunrise    = RST_SUNRISE_MINUTE;
      sched_sunset     = RST_SUNSET_MINUTE;
      sched_rise_ramp  = RST_SUNRISE_RAMP;
      sched_set_ramp   = RST_SUNSET_RAMP;
      sched_off_enable = RST_AUTO_OFF_EN;
      sched_off_minute = RST_TURNOFF_MINUTE;
      sched_day        = RST_DAY_LEVELS;
      sched_night      = RST_NIGHT_LEVELS;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_reset_schedule();
      test_register_limits();
      test_empty_schedule();
      test_random_schedules();
      wait_idle();

      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // watchdog
   initial begin
      for (watchdog_cycles = 0; watchdog_cycles < LIMIT_CYCLES; watchdog_cycles++)
         @(posedge clock);
      $display("timeout after %0d cycles, %0d targets outstanding",
               watchdog_cycles, pending_targets.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
